@@ rtl/servo_control_mixer_assert.svh @@
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef SERVO_CONTROL_MIXER_ASSERT_SVH
`define SERVO_CONTROL_MIXER_ASSERT_SVH

// ante in this cycle implies cons in the same cycle
`define SCM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante in this cycle implies cons in the next cycle
`define SCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/scm_pkg.sv @@
package scm_pkg;

    localparam int PW_W  = 13;
    localparam int CMD_W = 16;
    // internal sum width: boosted base plus three command terms, with margin
    localparam int SUM_W = 24;

    localparam logic [PW_W-1:0] NEUTRAL   = 13'd3000;
    localparam logic [PW_W-1:0] FIELD_MAX = 13'd8191;

    // register indexes
    localparam logic [2:0] REG_AIRFRAME_MODE  = 3'd0;
    localparam logic [2:0] REG_REVERSE_MASK   = 3'd1;
    localparam logic [2:0] REG_TRIM_AILERON   = 3'd2;
    localparam logic [2:0] REG_TRIM_ELEVATOR  = 3'd3;
    localparam logic [2:0] REG_TRIM_RUDDER    = 3'd4;
    localparam logic [2:0] REG_TRIM_THROTTLE  = 3'd5;
    localparam logic [2:0] REG_TRIM_SECONDARY = 3'd6;

    // airframe modes
    localparam logic [1:0] MODE_STANDARD = 2'd0;
    localparam logic [1:0] MODE_VTAIL    = 2'd1;
    localparam logic [1:0] MODE_DELTA    = 2'd2;
    localparam logic [1:0] MODE_HELI     = 2'd3;

    // reverse mask bit positions
    localparam int REV_AILERON   = 0;
    localparam int REV_SECONDARY = 1;
    localparam int REV_ELEVATOR  = 2;
    localparam int REV_RUDDER    = 3;
    localparam int REV_THROTTLE  = 4;
    localparam int REV_SURFACE   = 5;

    typedef struct packed {
        logic [1:0]      airframe_mode;
        logic [5:0]      reverse_mask;
        logic [PW_W-1:0] trim_aileron;
        logic [PW_W-1:0] trim_elevator;
        logic [PW_W-1:0] trim_rudder;
        logic [PW_W-1:0] trim_throttle;
        logic [PW_W-1:0] trim_secondary;
    } cfg_t;

    typedef struct packed {
        logic                    link_ok;
        logic                    stabilized;
        logic [PW_W-1:0]         aileron_in;
        logic [PW_W-1:0]         elevator_in;
        logic [PW_W-1:0]         rudder_in;
        logic [PW_W-1:0]         throttle_in;
        logic [PW_W-1:0]         secondary_in;
        logic signed [CMD_W-1:0] roll_cmd;
        logic signed [CMD_W-1:0] pitch_cmd;
        logic signed [CMD_W-1:0] yaw_cmd;
        logic signed [CMD_W-1:0] waggle_cmd;
        logic signed [CMD_W-1:0] altitude_cmd;
    } cmd_t;

    typedef struct packed {
        logic [PW_W-1:0] aileron_out;
        logic [PW_W-1:0] secondary_out;
        logic [PW_W-1:0] elevator_out;
        logic [PW_W-1:0] rudder_out;
        logic [PW_W-1:0] throttle_out;
    } servo_t;

endpackage

@@ rtl/scm_mix.sv @@
module scm_mix #(
    parameter int PULSE_MIN     = 2000,
    parameter int PULSE_MAX     = 4000,
    parameter int AILERON_GAIN  = 0,
    parameter int ELEVATOR_GAIN = 0,
    parameter int RUDDER_GAIN   = 0
) (
    input  scm_pkg::cfg_t   cfg,
    input  scm_pkg::cmd_t   cmd,
    output scm_pkg::servo_t servo
);
    import scm_pkg::*;

    localparam logic signed [SUM_W-1:0] LO       = SUM_W'(PULSE_MIN);
    localparam logic signed [SUM_W-1:0] HI       = SUM_W'(PULSE_MAX);
    localparam logic signed [SUM_W-1:0] A_GAIN   = SUM_W'(AILERON_GAIN);
    localparam logic signed [SUM_W-1:0] E_GAIN   = SUM_W'(ELEVATOR_GAIN);
    localparam logic signed [SUM_W-1:0] R_GAIN   = SUM_W'(RUDDER_GAIN);
    localparam logic signed [SUM_W-1:0] ZERO_X   = '0;
    localparam logic signed [SUM_W-1:0] NEUT_X   = {{(SUM_W-PW_W){1'b0}}, NEUTRAL};
    localparam logic signed [SUM_W-1:0] FMAX_X   = {{(SUM_W-PW_W){1'b0}}, FIELD_MAX};

    function automatic logic signed [SUM_W-1:0] ext_pw(input logic [PW_W-1:0] v);
        return $signed({{(SUM_W-PW_W){1'b0}}, v});
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_cmd(input logic [CMD_W-1:0] v);
        return $signed({{(SUM_W-CMD_W){v[CMD_W-1]}}, v});
    endfunction

    function automatic logic signed [SUM_W-1:0] rev(input logic neg,
                                                   input logic signed [SUM_W-1:0] v);
        return neg ? -v : v;
    endfunction

    // upper limit first, then lower, so a crossed pair of limits gives the lower one
    function automatic logic [PW_W-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                              input logic signed [SUM_W-1:0] lo,
                                              input logic signed [SUM_W-1:0] hi);
        logic signed [SUM_W-1:0] t;
        t = v;
        if (t > hi)
            t = hi;
        if (t < lo)
            t = lo;
        return t[PW_W-1:0];
    endfunction

    logic                    boost_en;
    logic signed [SUM_W-1:0] ma, me, mr, mt, ms;
    logic signed [SUM_W-1:0] prod_a, prod_e, prod_r;
    logic signed [SUM_W-1:0] ba, be, br;
    logic signed [SUM_W-1:0] roll, pitch, yaw, wag, alt;
    logic signed [SUM_W-1:0] roll_adj, pitch_adj, hr, hp;
    logic signed [SUM_W-1:0] vy, dr;
    logic [5:0]              rm;
    logic [PW_W-1:0]         ail, sec, ele, rud, thr;

    assign rm       = cfg.reverse_mask;
    assign boost_en = cmd.link_ok & cmd.stabilized;

    assign ma = ext_pw(cmd.link_ok ? cmd.aileron_in   : cfg.trim_aileron);
    assign me = ext_pw(cmd.link_ok ? cmd.elevator_in  : cfg.trim_elevator);
    assign mr = ext_pw(cmd.link_ok ? cmd.rudder_in    : cfg.trim_rudder);
    assign mt = ext_pw(cmd.link_ok ? cmd.throttle_in  : cfg.trim_throttle);
    assign ms = ext_pw(cmd.link_ok ? cmd.secondary_in : cfg.trim_secondary);

    // stick boost: base + floor(((base - trim) * gain) / 8)
    assign prod_a = (ma - ext_pw(cfg.trim_aileron))  * A_GAIN;
    assign prod_e = (me - ext_pw(cfg.trim_elevator)) * E_GAIN;
    assign prod_r = (mr - ext_pw(cfg.trim_rudder))   * R_GAIN;

    assign ba = boost_en ? ma + (prod_a >>> 3) : ma;
    assign be = boost_en ? me + (prod_e >>> 3) : me;
    assign br = boost_en ? mr + (prod_r >>> 3) : mr;

    assign roll  = ext_cmd(cmd.roll_cmd);
    assign pitch = ext_cmd(cmd.pitch_cmd);
    assign yaw   = ext_cmd(cmd.yaw_cmd);
    assign wag   = ext_cmd(cmd.waggle_cmd);
    assign alt   = ext_cmd(cmd.altitude_cmd);

    // halving toward zero: add one to negatives before the arithmetic shift
    assign roll_adj  = roll  + $signed({{(SUM_W-1){1'b0}}, roll[SUM_W-1]});
    assign pitch_adj = pitch + $signed({{(SUM_W-1){1'b0}}, pitch[SUM_W-1]});
    assign hr        = roll_adj  >>> 1;
    assign hp        = pitch_adj >>> 1;

    assign vy = rev(rm[REV_SURFACE], yaw);
    assign dr = rev(rm[REV_SURFACE], roll);

    always_comb
    begin
        ail = '0;
        sec = '0;
        ele = '0;
        rud = '0;
        unique case (cfg.airframe_mode)
            MODE_STANDARD:
            begin
                ail = clamp(ba + rev(rm[REV_AILERON], roll + wag), LO, HI);
                sec = clamp(NEUT_X + rev(rm[REV_SECONDARY], ext_pw(ail) - NEUT_X),
                            ZERO_X, FMAX_X);
                ele = clamp(be + rev(rm[REV_ELEVATOR], pitch), LO, HI);
                rud = clamp(br + rev(rm[REV_RUDDER], yaw - wag), LO, HI);
            end
            MODE_VTAIL:
            begin
                ail = clamp(ba + rev(rm[REV_AILERON], roll + wag), LO, HI);
                sec = clamp(NEUT_X + rev(rm[REV_SECONDARY], ext_pw(ail) - NEUT_X),
                            ZERO_X, FMAX_X);
                ele = clamp(be + rev(rm[REV_ELEVATOR], pitch + vy), LO, HI);
                rud = clamp(br + rev(rm[REV_RUDDER], pitch - vy), LO, HI);
            end
            MODE_DELTA:
            begin
                ail = clamp(ba + rev(rm[REV_AILERON], pitch - dr - wag), LO, HI);
                sec = NEUTRAL;
                ele = clamp(be + rev(rm[REV_ELEVATOR], dr + pitch + wag), LO, HI);
                rud = clamp(br + rev(rm[REV_RUDDER], yaw), LO, HI);
            end
            MODE_HELI:
            begin
                // secondary takes the unboosted base and the field range only
                ail = clamp(ba + rev(rm[REV_AILERON], hr + hp), LO, HI);
                sec = clamp(ms + rev(rm[REV_SECONDARY], hp - hr), ZERO_X, FMAX_X);
                ele = clamp(be + rev(rm[REV_ELEVATOR], pitch), LO, HI);
                rud = clamp(br, LO, HI);
            end
        endcase
    end

    // a zero throttle base means motor off
    assign thr = (mt == ZERO_X) ? '0 : clamp(mt + rev(rm[REV_THROTTLE], alt), LO, HI);

    assign servo.aileron_out   = ail;
    assign servo.secondary_out = sec;
    assign servo.elevator_out  = ele;
    assign servo.rudder_out    = rud;
    assign servo.throttle_out  = thr;

endmodule

@@ rtl/servo_control_mixer.sv @@
// A word taken into the input register moves on to the result register, which
// offers it on servo. Throughput: one word per cycle unless servo stalls; the
// mix is a single pass between the two registers, with no loop or shared unit.
// Backpressure on servo stalls cmd only once both registers hold a word.
// Reset clears both valid flags and loads the register defaults at once.
`include "servo_control_mixer_assert.svh"

module servo_control_mixer #(
    parameter int PULSE_MIN     = 2000,
    parameter int PULSE_MAX     = 4000,
    parameter int AILERON_GAIN  = 0,
    parameter int ELEVATOR_GAIN = 0,
    parameter int RUDDER_GAIN   = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  scm_pkg::cmd_t   cmd,
    output logic            servo_valid,
    input  logic            servo_stall,
    output scm_pkg::servo_t servo,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [12:0]     cfg_data
);
    import scm_pkg::*;

    localparam logic [PW_W-1:0] PMIN_PW = PW_W'(PULSE_MIN);
    localparam logic [PW_W-1:0] PMAX_PW = PW_W'(PULSE_MAX);

    localparam cfg_t CFG_RESET = '{
        airframe_mode:  MODE_STANDARD,
        reverse_mask:   6'd0,
        trim_aileron:   NEUTRAL,
        trim_elevator:  NEUTRAL,
        trim_rudder:    NEUTRAL,
        trim_throttle:  13'd0,
        trim_secondary: NEUTRAL
    };

    cfg_t   cfg_reg, cfg_next;
    logic   in_valid_reg, in_valid_next;
    cmd_t   in_reg;
    logic   out_valid_reg, out_valid_next;
    servo_t out_reg;
    servo_t mix_result;
    logic   out_adv, in_adv;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AIRFRAME_MODE:  cfg_next.airframe_mode  = cfg_data[1:0];
                REG_REVERSE_MASK:   cfg_next.reverse_mask   = cfg_data[5:0];
                REG_TRIM_AILERON:   cfg_next.trim_aileron   = cfg_data;
                REG_TRIM_ELEVATOR:  cfg_next.trim_elevator  = cfg_data;
                REG_TRIM_RUDDER:    cfg_next.trim_rudder    = cfg_data;
                REG_TRIM_THROTTLE:  cfg_next.trim_throttle  = cfg_data;
                REG_TRIM_SECONDARY: cfg_next.trim_secondary = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // two-register pipe: result register moves when empty or taken
    assign out_adv   = !out_valid_reg || !servo_stall;
    assign in_adv    = !in_valid_reg || out_adv;
    assign cmd_stall = !in_adv;

    assign in_valid_next  = in_adv  ? cmd_valid    : in_valid_reg;
    assign out_valid_next = out_adv ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && cmd_valid)
            in_reg <= cmd;
        if (out_adv && in_valid_reg)
            out_reg <= mix_result;
    end

    scm_mix #(
        .PULSE_MIN     (PULSE_MIN),
        .PULSE_MAX     (PULSE_MAX),
        .AILERON_GAIN  (AILERON_GAIN),
        .ELEVATOR_GAIN (ELEVATOR_GAIN),
        .RUDDER_GAIN   (RUDDER_GAIN)
    ) u_mix (
        .cfg   (cfg_reg),
        .cmd   (in_reg),
        .servo (mix_result)
    );

    assign servo_valid = out_valid_reg;
    assign servo       = out_reg;

    `SCM_ASSERT_SAME(a_stall_only_when_full, cmd_stall, in_valid_reg && out_valid_reg,
        "cmd stalled with a free register")
    `SCM_ASSERT_NEXT(a_input_moves_on, in_valid_reg && !out_valid_reg, out_valid_reg,
        "word did not move to result register")
    `SCM_ASSERT_SAME(a_throttle_range, servo_valid,
        servo.throttle_out == '0 || servo.throttle_out == PMIN_PW ||
        (servo.throttle_out >= PMIN_PW && servo.throttle_out <= PMAX_PW),
        "throttle outside pulse limits")
    `SCM_ASSERT_SAME(a_aileron_range, servo_valid,
        servo.aileron_out == PMIN_PW ||
        (servo.aileron_out >= PMIN_PW && servo.aileron_out <= PMAX_PW),
        "aileron outside pulse limits")

endmodule

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scm_pkg::*;

    localparam int P_MIN      = 2000;
    localparam int P_MAX      = 4000;
    localparam int G_AILERON  = 0;
    localparam int G_ELEVATOR = 0;
    localparam int G_RUDDER   = 0;
    localparam int LIMIT_CYCLES = 400000;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    cmd_t        cmd;
    logic        servo_valid;
    logic        servo_stall;
    servo_t      servo;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;

    // shadow of the mixer's registers
    logic [1:0]  frame_mode;
    logic [5:0]  rev_mask;
    logic [12:0] trim_ail;
    logic [12:0] trim_ele;
    logic [12:0] trim_rud;
    logic [12:0] trim_thr;
    logic [12:0] trim_sec;

    servo_t servo_due[$];
    int     bad_fields;
    int     cycles;
    bit     idle_en;

    servo_control_mixer #(
        .PULSE_MIN     (P_MIN),
        .PULSE_MAX     (P_MAX),
        .AILERON_GAIN  (G_AILERON),
        .ELEVATOR_GAIN (G_ELEVATOR),
        .RUDDER_GAIN   (G_RUDDER)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .servo_valid (servo_valid),
        .servo_stall (servo_stall),
        .servo       (servo),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int clip(int v, int lo, int hi);
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v;
    endfunction

    function automatic int flip(int pos, int v);
        return rev_mask[pos] ? -v : v;
    endfunction

    // stick boost: arithmetic shift floors
    function automatic int boost(int base, int trim, int gain);
        int prod;
        prod = (base - trim) * gain;
        return base + (prod >>> 3);
    endfunction

    function automatic servo_t mix_servo(cmd_t w);
        servo_t r;
        int ma, me, mr, mt, ms;
        int roll, pitch, yaw, wag, alt;
        int ail, sec, ele, rud, thr, sv, hr, hp;
        ma = w.link_ok ? int'(w.aileron_in)   : int'(trim_ail);
        me = w.link_ok ? int'(w.elevator_in)  : int'(trim_ele);
        mr = w.link_ok ? int'(w.rudder_in)    : int'(trim_rud);
        mt = w.link_ok ? int'(w.throttle_in)  : int'(trim_thr);
        ms = w.link_ok ? int'(w.secondary_in) : int'(trim_sec);
        roll  = $signed(w.roll_cmd);
        pitch = $signed(w.pitch_cmd);
        yaw   = $signed(w.yaw_cmd);
        wag   = $signed(w.waggle_cmd);
        alt   = $signed(w.altitude_cmd);
        if (w.link_ok && w.stabilized)
        begin
            ma = boost(ma, trim_ail, G_AILERON);
            me = boost(me, trim_ele, G_ELEVATOR);
            mr = boost(mr, trim_rud, G_RUDDER);
        end
        case (frame_mode)
            MODE_STANDARD:
            begin
                ail = clip(ma + flip(REV_AILERON, roll + wag), P_MIN, P_MAX);
                sec = clip(int'(NEUTRAL) + flip(REV_SECONDARY, ail - int'(NEUTRAL)),
                           0, int'(FIELD_MAX));
                ele = clip(me + flip(REV_ELEVATOR, pitch), P_MIN, P_MAX);
                rud = clip(mr + flip(REV_RUDDER, yaw - wag), P_MIN, P_MAX);
            end
            MODE_VTAIL:
            begin
                sv  = flip(REV_SURFACE, yaw);
                ail = clip(ma + flip(REV_AILERON, roll + wag), P_MIN, P_MAX);
                sec = clip(int'(NEUTRAL) + flip(REV_SECONDARY, ail - int'(NEUTRAL)),
                           0, int'(FIELD_MAX));
                ele = clip(me + flip(REV_ELEVATOR, pitch + sv), P_MIN, P_MAX);
                rud = clip(mr + flip(REV_RUDDER, pitch - sv), P_MIN, P_MAX);
            end
            MODE_DELTA:
            begin
                sv  = flip(REV_SURFACE, roll);
                ail = clip(ma + flip(REV_AILERON, -sv + pitch - wag), P_MIN, P_MAX);
                sec = int'(NEUTRAL);
                ele = clip(me + flip(REV_ELEVATOR, sv + pitch + wag), P_MIN, P_MAX);
                rud = clip(mr + flip(REV_RUDDER, yaw), P_MIN, P_MAX);
            end
            default:
            begin
                // int division truncates toward zero
                hr  = roll / 2;
                hp  = pitch / 2;
                ail = clip(ma + flip(REV_AILERON, hr + hp), P_MIN, P_MAX);
                ele = clip(me + flip(REV_ELEVATOR, pitch), P_MIN, P_MAX);
                sec = clip(ms + flip(REV_SECONDARY, hp - hr), 0, int'(FIELD_MAX));
                rud = clip(mr, P_MIN, P_MAX);
            end
        endcase
        if (mt == 0)
            thr = 0;
        else
            thr = clip(mt + flip(REV_THROTTLE, alt), P_MIN, P_MAX);
        r.aileron_out   = ail[12:0];
        r.secondary_out = sec[12:0];
        r.elevator_out  = ele[12:0];
        r.rudder_out    = rud[12:0];
        r.throttle_out  = thr[12:0];
        return r;
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got)
        begin
            bad_fields++;
            if (bad_fields <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin : servo_check
        servo_t want;
        if (rst_n && servo_valid && !servo_stall)
        begin
            if (servo_due.size() == 0)
            begin
                bad_fields++;
                if (bad_fields <= 10)
                    $display("mismatch: servo word with none expected (%h)", servo);
            end
            else
            begin
                want = servo_due.pop_front();
                compare_field("aileron_out",   want.aileron_out,   servo.aileron_out);
                compare_field("secondary_out", want.secondary_out, servo.secondary_out);
                compare_field("elevator_out",  want.elevator_out,  servo.elevator_out);
                compare_field("rudder_out",    want.rudder_out,    servo.rudder_out);
                compare_field("throttle_out",  want.throttle_out,  servo.throttle_out);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver backpressure in bursts
    initial
    begin
        servo_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_en && rst_n && $urandom_range(0, 7) == 0)
            begin
                servo_stall = 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                servo_stall = 1'b0;
            end
        end
    end

    task automatic send_word(input cmd_t w);
        servo_t want;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            cmd_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        cmd       = w;
        cmd_valid = 1'b1;
        want      = mix_servo(w);
        do
            @(posedge clk);
        while (cmd_stall);
        servo_due.push_back(want);
    endtask

    // drop valid and let every outstanding word come back
    task automatic drain;
        @(negedge clk);
        cmd_valid = 1'b0;
        while (servo_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [12:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_AIRFRAME_MODE:  frame_mode = val[1:0];
            REG_REVERSE_MASK:   rev_mask   = val[5:0];
            REG_TRIM_AILERON:   trim_ail   = val;
            REG_TRIM_ELEVATOR:  trim_ele   = val;
            REG_TRIM_RUDDER:    trim_rud   = val;
            REG_TRIM_THROTTLE:  trim_thr   = val;
            REG_TRIM_SECONDARY: trim_sec   = val;
            default: ;
        endcase
    endtask

    function automatic logic [12:0] rand_pw();
        case ($urandom_range(0, 7))
            0:       return 13'd0;
            1:       return 13'd8191;
            2, 3:    return 13'($urandom);
            default: return 13'($urandom_range(1500, 4500));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_corr();
        case ($urandom_range(0, 7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    function automatic cmd_t rand_word();
        cmd_t w;
        w.link_ok      = ($urandom_range(0, 3) != 0);
        w.stabilized   = 1'($urandom);
        w.aileron_in   = rand_pw();
        w.elevator_in  = rand_pw();
        w.rudder_in    = rand_pw();
        w.throttle_in  = rand_pw();
        w.secondary_in = rand_pw();
        w.roll_cmd     = rand_corr();
        w.pitch_cmd    = rand_corr();
        w.yaw_cmd      = rand_corr();
        w.waggle_cmd   = rand_corr();
        w.altitude_cmd = rand_corr();
        return w;
    endfunction

    function automatic cmd_t flat_word(logic radio, logic stab, logic [12:0] pw,
                                       logic signed [15:0] corr);
        cmd_t w;
        w.link_ok      = radio;
        w.stabilized   = stab;
        w.aileron_in   = pw;
        w.elevator_in  = pw;
        w.rudder_in    = pw;
        w.throttle_in  = pw;
        w.secondary_in = pw;
        w.roll_cmd     = corr;
        w.pitch_cmd    = corr;
        w.yaw_cmd      = corr;
        w.waggle_cmd   = corr;
        w.altitude_cmd = corr;
        return w;
    endfunction

    function automatic logic [12:0] rand_trim();
        case ($urandom_range(0, 5))
            0:       return 13'd0;
            1:       return 13'd8191;
            2:       return 13'($urandom);
            default: return 13'($urandom_range(1500, 4500));
        endcase
    endfunction

    // defaults straight out of reset: trims stand in with radio off,
    // zero throttle trim gives zero throttle
    task automatic test_reset_defaults;
        send_word(flat_word(1'b0, 1'b0, 13'd0, 16'sd0));
        send_word(flat_word(1'b0, 1'b1, 13'd8191, 16'sd100));
        send_word(flat_word(1'b1, 1'b0, 13'd0, 16'sd0));
        send_word(flat_word(1'b1, 1'b1, 13'd8191, 16'sd32767));
        send_word(flat_word(1'b1, 1'b0, 13'd3000, -16'sd32768));
        send_word(flat_word(1'b1, 1'b1, 13'd3000, 16'sd250));
        drain();
    endtask

    task automatic test_each_airframe;
        cmd_t w;
        for (int m = 0; m < 4; m++)
        begin
            set_reg(REG_AIRFRAME_MODE, 13'(m));
            set_reg(REG_REVERSE_MASK, (m % 2) ? 13'd63 : 13'd0);
            send_word(flat_word(1'b1, 1'b0, 13'd3000, 16'sd300));
            send_word(flat_word(1'b1, 1'b1, 13'd2500, -16'sd700));
            send_word(flat_word(1'b1, 1'b0, 13'd8191, -16'sd32768));
            drain();
        end
        // helicopter halving of odd negatives, and secondary clamps at both ends
        set_reg(REG_AIRFRAME_MODE, 13'(MODE_HELI));
        set_reg(REG_REVERSE_MASK, 13'd0);
        w = flat_word(1'b1, 1'b0, 13'd3000, 16'sd0);
        w.roll_cmd  = -16'sd3;
        w.pitch_cmd = -16'sd5;
        send_word(w);
        w.secondary_in = 13'd8191;
        w.roll_cmd     = -16'sd32768;
        w.pitch_cmd    = 16'sd32767;
        send_word(w);
        w.secondary_in = 13'd0;
        w.roll_cmd     = 16'sd32767;
        w.pitch_cmd    = -16'sd32768;
        send_word(w);
        drain();
        // extreme trims with radio off
        set_reg(REG_TRIM_AILERON, 13'd8191);
        set_reg(REG_TRIM_ELEVATOR, 13'd0);
        set_reg(REG_TRIM_RUDDER, 13'd8191);
        set_reg(REG_TRIM_THROTTLE, 13'd8191);
        set_reg(REG_TRIM_SECONDARY, 13'd8191);
        send_word(flat_word(1'b0, 1'b1, 13'd0, 16'sd32767));
        drain();
        set_reg(REG_AIRFRAME_MODE, 13'(MODE_STANDARD));
        send_word(flat_word(1'b0, 1'b0, 13'd0, -16'sd32768));
        drain();
    endtask

    task automatic test_random_mix(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            set_reg(REG_AIRFRAME_MODE, 13'(p % 4));
            case ($urandom_range(0, 3))
                0:       set_reg(REG_REVERSE_MASK, 13'd0);
                1:       set_reg(REG_REVERSE_MASK, 13'd63);
                default: set_reg(REG_REVERSE_MASK, 13'($urandom_range(0, 63)));
            endcase
            set_reg(REG_TRIM_AILERON, rand_trim());
            set_reg(REG_TRIM_ELEVATOR, rand_trim());
            set_reg(REG_TRIM_RUDDER, rand_trim());
            set_reg(REG_TRIM_THROTTLE, rand_trim());
            set_reg(REG_TRIM_SECONDARY, rand_trim());
            for (int i = 0; i < per_phase; i++)
                send_word(rand_word());
            drain();
        end
    endtask

    // back-to-back words with neither side idling
    task automatic test_full_rate;
        idle_en = 1'b0;
        test_random_mix(4, 40);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        cmd        = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idle_en    = 1'b1;
        bad_fields = 0;
        cycles     = 0;
        frame_mode = MODE_STANDARD;
        rev_mask   = 6'd0;
        trim_ail   = 13'd3000;
        trim_ele   = 13'd3000;
        trim_rud   = 13'd3000;
        trim_thr   = 13'd0;
        trim_sec   = 13'd3000;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_each_airframe();
        test_random_mix(12, 75);
        test_full_rate();

        if (bad_fields == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
